### sv/swt_pkg.sv
`default_nettype none
package swt_pkg;
  localparam int unsigned RxDepth    = 32;
  localparam int unsigned TxDepth    = 32;
  localparam int unsigned MaxPayload = 1024;
  localparam int unsigned RxAw       = $clog2(RxDepth);
  localparam int unsigned TxAw       = $clog2(TxDepth);
  localparam int unsigned DescW      = 27;

  typedef logic [DescW-1:0] desc_t;

  typedef enum logic [2:0] {
    KIND_DELIVER = 3'd0,
    KIND_SEND    = 3'd1,
    KIND_RESEND  = 3'd2,
    KIND_ACK     = 3'd3,
    KIND_REFUSED = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    OP_RX   = 2'd0,
    OP_SEND = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [0:0] {
    CFG_WINDOW  = 1'b0,
    CFG_TIMEOUT = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RX_WR,
    ST_RUN_RD,
    ST_RUN_OUT,
    ST_ACK,
    ST_RESEND
  } state_t;
endpackage
`default_nettype wire

### sv/sliding_window_transport.sv
// Channel  | Handshake            | Payload
// in_      | start & !busy        | op, pkt_seq, pkt_ack, payload_ref, payload_len
// out_     | out_valid (1 cycle)  | kind, out_seq, out_ack, out_ref, out_len, out_last
// cfg_     | cfg_valid & cfg_ready| cfg_index, cfg_data
// A send's result is registered and follows in the next cycle; a tick that does
// not resend gives no result, and a tick that resends goes through ST_RESEND.
// A received packet goes through ST_RX_WR, ST_RUN_RD, ST_RUN_OUT per delivered
// packet, then ST_ACK; the in-order run walks the reorder memory one entry per read.
// Reset is synchronous and active low; memories are not cleared, only the
// presence bits. Results cannot be stalled; configuration is taken only while idle.
`default_nettype none
module sliding_window_transport (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_op,
  input  wire logic [31:0] in_pkt_seq,
  input  wire logic [31:0] in_pkt_ack,
  input  wire logic [15:0] in_payload_ref,
  input  wire logic [10:0] in_payload_len,
  output logic             out_valid,
  output logic [2:0]       out_kind,
  output logic [31:0]      out_seq,
  output logic [31:0]      out_ack,
  output logic [15:0]      out_ref,
  output logic [10:0]      out_len,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  localparam int unsigned RxAw = swt_pkg::RxAw;
  localparam int unsigned TxAw = swt_pkg::TxAw;

  swt_pkg::desc_t rx_mem [swt_pkg::RxDepth];
  swt_pkg::desc_t tx_mem [swt_pkg::TxDepth];
  swt_pkg::desc_t rx_rd_r, tx_rd_r;

  logic [5:0]  window_r;
  logic [15:0] timeout_r;
  logic [swt_pkg::RxDepth-1:0] present_r, present_nxt;
  logic [31:0] rx_exp_r, rx_exp_nxt, next_seq_r, next_seq_nxt, acked_r, acked_nxt;
  logic        wfull_r, wfull_nxt, trun_r, trun_nxt;
  logic [15:0] tcnt_r, tcnt_nxt;
  swt_pkg::state_t state_r, state_nxt;
  logic [31:0] seq_r, ack_r;
  swt_pkg::desc_t desc_r;
  logic        seq_nz_r;

  logic        ov_nxt, olast_nxt;
  logic [2:0]  okind_nxt;
  logic [31:0] oseq_nxt, oack_nxt;
  swt_pkg::desc_t odesc_nxt;
  swt_pkg::desc_t odesc_r;

  logic        rx_we, tx_we;
  logic [RxAw-1:0] rx_wa, rx_ra;
  logic [TxAw-1:0] tx_wa, tx_ra;
  swt_pkg::desc_t  rx_wd, tx_wd;

  logic [31:0] eff_win;
  logic [31:0] in_off, outstanding, ack_off, ack_span;
  logic [15:0] limit, tinc;
  swt_pkg::desc_t in_desc;

  assign busy      = (state_r != swt_pkg::ST_IDLE);
  assign cfg_ready = !busy;
  assign out_ref   = odesc_r[15:0];
  assign out_len   = odesc_r[26:16];
  assign in_desc   = {in_payload_len, in_payload_ref};

  always_comb begin
    if (window_r == 6'd0) eff_win = 32'd1;
    else if ({26'd0, window_r} > 32'(swt_pkg::TxDepth)) eff_win = 32'(swt_pkg::TxDepth);
    else eff_win = {26'd0, window_r};
  end

  always_ff @(posedge clk) begin
    if (rx_we) rx_mem[rx_wa] <= rx_wd;
    rx_rd_r <= rx_mem[rx_ra];
    if (tx_we) tx_mem[tx_wa] <= tx_wd;
    tx_rd_r <= tx_mem[tx_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r  <= 6'd20;
      timeout_r <= 16'd5;
      present_r <= '0;
      rx_exp_r  <= 32'd1;
      next_seq_r <= 32'd1;
      acked_r   <= '0;
      wfull_r   <= 1'b0;
      trun_r    <= 1'b0;
      tcnt_r    <= '0;
      state_r   <= swt_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          swt_pkg::CFG_WINDOW:  window_r  <= cfg_data[5:0];
          swt_pkg::CFG_TIMEOUT: timeout_r <= cfg_data;
          default: ;
        endcase
      end
      present_r  <= present_nxt;
      rx_exp_r   <= rx_exp_nxt;
      next_seq_r <= next_seq_nxt;
      acked_r    <= acked_nxt;
      wfull_r    <= wfull_nxt;
      trun_r     <= trun_nxt;
      tcnt_r     <= tcnt_nxt;
      state_r    <= state_nxt;
      out_valid  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      seq_r    <= in_pkt_seq;
      ack_r    <= in_pkt_ack;
      desc_r   <= in_desc;
      seq_nz_r <= (in_pkt_seq != 32'd0);
    end
    out_kind <= okind_nxt;
    out_seq  <= oseq_nxt;
    out_ack  <= oack_nxt;
    odesc_r  <= odesc_nxt;
    out_last <= olast_nxt;
  end

  always_comb begin
    present_nxt = present_r;
    rx_exp_nxt = rx_exp_r;
    next_seq_nxt = next_seq_r;
    acked_nxt = acked_r;
    wfull_nxt = wfull_r;
    trun_nxt = trun_r;
    tcnt_nxt = tcnt_r;
    state_nxt = state_r;
    ov_nxt = 1'b0;
    olast_nxt = 1'b0;
    okind_nxt = swt_pkg::KIND_DELIVER;
    oseq_nxt = '0;
    oack_nxt = '0;
    odesc_nxt = '0;
    rx_we = 1'b0;
    rx_wa = seq_r[RxAw-1:0];
    rx_wd = desc_r;
    rx_ra = rx_exp_r[RxAw-1:0];
    tx_we = 1'b0;
    tx_wa = next_seq_r[TxAw-1:0];
    tx_wd = in_desc;
    tx_ra = acked_r[TxAw-1:0] + TxAw'(1);
    in_off = seq_r - rx_exp_r;
    outstanding = next_seq_r - 32'd1 - acked_r;
    ack_span = next_seq_r - 32'd1 - acked_r;
    ack_off = ack_r - acked_r;
    limit = (timeout_r == 16'd0) ? 16'd1 : timeout_r;
    tinc = (tcnt_r != 16'hFFFF) ? tcnt_r + 16'd1 : tcnt_r;

    case (state_r)
      swt_pkg::ST_IDLE: begin
        if (start) begin
          case (in_op)
            swt_pkg::OP_RX: state_nxt = swt_pkg::ST_RX_WR;
            swt_pkg::OP_SEND: begin
              ov_nxt = 1'b1;
              olast_nxt = 1'b1;
              if (wfull_r || outstanding >= 32'(swt_pkg::TxDepth) ||
                  in_payload_len == 11'd0 ||
                  {21'd0, in_payload_len} > 32'(swt_pkg::MaxPayload)) begin
                okind_nxt = swt_pkg::KIND_REFUSED;
              end else begin
                tx_we = 1'b1;
                okind_nxt = swt_pkg::KIND_SEND;
                oseq_nxt = next_seq_r;
                odesc_nxt = in_desc;
                next_seq_nxt = next_seq_r + 32'd1;
                trun_nxt = 1'b1;
                tcnt_nxt = '0;
                if (next_seq_r + 32'd1 - acked_r > eff_win) wfull_nxt = 1'b1;
              end
            end
            swt_pkg::OP_TICK: begin
              if (trun_r) begin
                tcnt_nxt = tinc;
                if (tinc >= limit) begin
                  if (acked_r == next_seq_r - 32'd1) begin
                    trun_nxt = 1'b0;
                    tcnt_nxt = '0;
                  end else begin
                    state_nxt = swt_pkg::ST_RESEND;
                    trun_nxt = 1'b1;
                    tcnt_nxt = '0;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
      swt_pkg::ST_RESEND: begin
        ov_nxt = 1'b1;
        olast_nxt = 1'b1;
        okind_nxt = swt_pkg::KIND_RESEND;
        oseq_nxt = acked_r + 32'd1;
        odesc_nxt = tx_rd_r;
        state_nxt = swt_pkg::ST_IDLE;
      end
      swt_pkg::ST_RX_WR: begin
        // Store a new in-window packet and read the head; seq 0 goes to ST_ACK.
        if (seq_nz_r) begin
          if (in_off < 32'(swt_pkg::RxDepth) && !present_r[seq_r[RxAw-1:0]]) begin
            rx_we = 1'b1;
            present_nxt[seq_r[RxAw-1:0]] = 1'b1;
          end
          state_nxt = swt_pkg::ST_RUN_RD;
        end else begin
          state_nxt = swt_pkg::ST_ACK;
        end
      end
      swt_pkg::ST_RUN_RD: begin
        if (present_r[rx_exp_r[RxAw-1:0]]) state_nxt = swt_pkg::ST_RUN_OUT;
        else state_nxt = swt_pkg::ST_ACK;
      end
      swt_pkg::ST_RUN_OUT: begin
        ov_nxt = 1'b1;
        okind_nxt = swt_pkg::KIND_DELIVER;
        oseq_nxt = rx_exp_r;
        odesc_nxt = rx_rd_r;
        present_nxt[rx_exp_r[RxAw-1:0]] = 1'b0;
        rx_exp_nxt = rx_exp_r + 32'd1;
        // The read for the next entry is issued now at the advanced address.
        rx_ra = rx_exp_nxt[RxAw-1:0];
        if (present_r[rx_exp_nxt[RxAw-1:0]] &&
            rx_exp_nxt[RxAw-1:0] != rx_exp_r[RxAw-1:0]) state_nxt = swt_pkg::ST_RUN_OUT;
        else state_nxt = swt_pkg::ST_ACK;
      end
      swt_pkg::ST_ACK: begin
        if (seq_nz_r && rx_exp_r != 32'd1) begin
          ov_nxt = 1'b1;
          okind_nxt = swt_pkg::KIND_ACK;
          oack_nxt = rx_exp_r - 32'd1;
          olast_nxt = 1'b1;
        end
        if (ack_r != 32'd0 && ack_off <= ack_span) begin
          trun_nxt = 1'b1;
          tcnt_nxt = '0;
          acked_nxt = ack_r;
          if (next_seq_r - ack_r <= eff_win) wfull_nxt = 1'b0;
          if (ack_r == next_seq_r - 32'd1) trun_nxt = 1'b0;
        end
        state_nxt = swt_pkg::ST_IDLE;
      end
      default: state_nxt = swt_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### sv/swt_checker.sv
`default_nettype none
module swt_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       busy,
  input wire logic       out_valid,
  input wire logic [2:0] out_kind,
  input wire logic       out_last
);
  a_idle_rst: assert property (@(posedge clk) !rst_n |=> !busy && !out_valid)
    else $error("busy or output after reset");
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kind <= swt_pkg::KIND_REFUSED) else $error("bad kind");
  a_ack_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == swt_pkg::KIND_ACK |-> out_last) else $error("ack not last");
  a_send_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == swt_pkg::KIND_SEND || out_kind == swt_pkg::KIND_REFUSED)
    |-> out_last)
    else $error("send result not last");
  a_deliver_more: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == swt_pkg::KIND_DELIVER |-> !out_last && busy)
    else $error("delivery ended transaction");
endmodule
bind sliding_window_transport swt_checker u_swt_checker (
  .clk(clk), .rst_n(rst_n), .busy(busy),
  .out_valid(out_valid), .out_kind(out_kind), .out_last(out_last)
);
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;

  typedef struct packed {
    swt_pkg::op_t op;
    logic [31:0]  seq;
    logic [31:0]  ack;
    logic [15:0]  pref;
    logic [10:0]  plen;
  } pkt_item_t;

  typedef struct packed {
    swt_pkg::kind_t kind;
    logic [31:0]    seq;
    logic [31:0]    ack;
    logic [15:0]    oref;
    logic [10:0]    olen;
    logic           last;
  } link_event_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_op = '0;
  logic [31:0] in_pkt_seq = '0;
  logic [31:0] in_pkt_ack = '0;
  logic [15:0] in_payload_ref = '0;
  logic [10:0] in_payload_len = '0;
  logic        out_valid;
  logic [2:0]  out_kind;
  logic [31:0] out_seq;
  logic [31:0] out_ack;
  logic [15:0] out_ref;
  logic [10:0] out_len;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  sliding_window_transport u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_pkt_seq(in_pkt_seq), .in_pkt_ack(in_pkt_ack),
    .in_payload_ref(in_payload_ref), .in_payload_len(in_payload_len),
    .out_valid(out_valid), .out_kind(out_kind), .out_seq(out_seq),
    .out_ack(out_ack), .out_ref(out_ref), .out_len(out_len), .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state of the link endpoint.
  logic [5:0]  win_reg;
  logic [15:0] tmo_reg;
  logic        rx_held [swt_pkg::RxDepth];
  logic [26:0] rx_store [swt_pkg::RxDepth];
  logic [26:0] tx_store [swt_pkg::TxDepth];
  logic [31:0] rx_next;
  logic [31:0] tx_next;
  logic [31:0] tx_acked;
  logic        tx_full;
  logic        tmr_on;
  logic [15:0] tmr_cnt;

  pkt_item_t   pending_q[$];
  link_event_t expected_q[$];
  int          fail_count = 0;
  int          drv_gap = 0;
  logic        accepted = 1'b0;
  pkt_item_t   drv_item;
  link_event_t mon_exp;
  link_event_t mon_act;

  function automatic logic [31:0] eff_window();
    logic [31:0] w;
    w = {26'd0, win_reg};
    if (w == 32'd0) w = 32'd1;
    if (w > 32'(swt_pkg::TxDepth)) w = 32'(swt_pkg::TxDepth);
    return w;
  endfunction

  function automatic void push_event(swt_pkg::kind_t k, logic [31:0] s, logic [31:0] a,
                                     logic [26:0] d);
    link_event_t e;
    e.kind = k; e.seq = s; e.ack = a; e.oref = d[15:0]; e.olen = d[26:16];
    e.last = 1'b0;
    expected_q.insert(expected_q.size(), e);
  endfunction

  function automatic void enqueue(pkt_item_t it);
    pending_q.insert(pending_q.size(), it);
  endfunction

  function automatic void predict_link(pkt_item_t it);
    int          n0;
    logic [31:0] off, span, lowseq;
    logic [15:0] lim;
    logic [26:0] d;
    logic [swt_pkg::RxAw-1:0] rslot;
    logic [swt_pkg::TxAw-1:0] tslot;
    n0 = expected_q.size();
    d = {it.plen, it.pref};
    case (it.op)
      swt_pkg::OP_RX: begin
        if (it.seq != 32'd0) begin
          off = it.seq - rx_next;
          if (off < 32'(swt_pkg::RxDepth)) begin
            rslot = it.seq[swt_pkg::RxAw-1:0];
            if (!rx_held[rslot]) begin
              rx_held[rslot] = 1'b1;
              rx_store[rslot] = d;
            end
          end
          for (int i = 0; i < int'(swt_pkg::RxDepth); i++) begin
            rslot = rx_next[swt_pkg::RxAw-1:0];
            if (!rx_held[rslot]) break;
            push_event(swt_pkg::KIND_DELIVER, rx_next, 32'd0, rx_store[rslot]);
            rx_held[rslot] = 1'b0;
            rx_next = rx_next + 32'd1;
          end
          if (rx_next - 32'd1 != 32'd0)
            push_event(swt_pkg::KIND_ACK, 32'd0, rx_next - 32'd1, 27'd0);
        end
        if (it.ack != 32'd0) begin
          span = tx_next - 32'd1 - tx_acked;
          off = it.ack - tx_acked;
          if (off <= span) begin
            tmr_on = 1'b1; tmr_cnt = 16'd0;
            tx_acked = it.ack;
            if (tx_next - tx_acked <= eff_window()) tx_full = 1'b0;
            if (tx_acked == tx_next - 32'd1) tmr_on = 1'b0;
          end
        end
      end
      swt_pkg::OP_SEND: begin
        if (tx_full || (tx_next - 32'd1 - tx_acked) >= 32'(swt_pkg::TxDepth) ||
            it.plen == 11'd0 || {21'd0, it.plen} > 32'(swt_pkg::MaxPayload)) begin
          push_event(swt_pkg::KIND_REFUSED, 32'd0, 32'd0, 27'd0);
        end else begin
          tslot = tx_next[swt_pkg::TxAw-1:0];
          tx_store[tslot] = d;
          push_event(swt_pkg::KIND_SEND, tx_next, 32'd0, d);
          tx_next = tx_next + 32'd1;
          tmr_on = 1'b1; tmr_cnt = 16'd0;
          if (tx_next - tx_acked > eff_window()) tx_full = 1'b1;
        end
      end
      swt_pkg::OP_TICK: begin
        if (tmr_on) begin
          lim = (tmo_reg == 16'd0) ? 16'd1 : tmo_reg;
          if (tmr_cnt < 16'hFFFF) tmr_cnt = tmr_cnt + 16'd1;
          if (tmr_cnt >= lim) begin
            if (tx_acked == tx_next - 32'd1) begin
              tmr_on = 1'b0; tmr_cnt = 16'd0;
            end else begin
              lowseq = tx_acked + 32'd1;
              tslot = lowseq[swt_pkg::TxAw-1:0];
              push_event(swt_pkg::KIND_RESEND, lowseq, 32'd0, tx_store[tslot]);
              tmr_on = 1'b1; tmr_cnt = 16'd0;
            end
          end
        end
      end
      default: ;
    endcase
    if (expected_q.size() > n0) expected_q[expected_q.size()-1].last = 1'b1;
  endfunction

  // Driver: holds each transaction until it is accepted, then waits its drawn gap.
  always @(negedge clk) begin
    if (rst_n && !(start && !accepted)) begin
      if (drv_gap > 0) begin
        drv_gap <= drv_gap - 1;
        start <= 1'b0;
      end else if (pending_q.size() > 0) begin
        drv_item = pending_q.pop_front();
        in_op <= drv_item.op; in_pkt_seq <= drv_item.seq; in_pkt_ack <= drv_item.ack;
        in_payload_ref <= drv_item.pref; in_payload_len <= drv_item.plen;
        start <= 1'b1;
        drv_gap <= int'($urandom_range(0, 8));
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: prediction on acceptance, comparison on each strobe.
  always @(posedge clk) begin
    accepted <= rst_n && start && !busy;
    if (rst_n) begin
      if (start && !busy) begin
        predict_link({swt_pkg::op_t'(in_op), in_pkt_seq, in_pkt_ack, in_payload_ref,
                      in_payload_len});
      end
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result kind=%0d seq=%0d ack=%0d", $time,
                   out_kind, out_seq, out_ack);
          fail_count++;
        end else begin
          mon_exp = expected_q.pop_front();
          mon_act.kind = swt_pkg::kind_t'(out_kind);
          mon_act.seq = out_seq; mon_act.ack = out_ack;
          mon_act.oref = out_ref; mon_act.olen = out_len; mon_act.last = out_last;
          if (mon_exp != mon_act) begin
            $display("%0t: mismatch expected kind=%0d seq=%0d ack=%0d ref=%0h len=%0d last=%0b",
                     $time, mon_exp.kind, mon_exp.seq, mon_exp.ack, mon_exp.oref,
                     mon_exp.olen, mon_exp.last);
            $display("%0t:          actual kind=%0d seq=%0d ack=%0d ref=%0h len=%0d last=%0b",
                     $time, out_kind, out_seq, out_ack, out_ref, out_len, out_last);
            fail_count++;
          end
        end
      end
    end
  end

  function automatic pkt_item_t mk(swt_pkg::op_t op, logic [31:0] s, logic [31:0] a,
                                   logic [15:0] r, logic [10:0] l);
    pkt_item_t it;
    it.op = op; it.seq = s; it.ack = a; it.pref = r; it.plen = l;
    return it;
  endfunction

  function automatic logic [10:0] rnd_len();
    logic [10:0] l;
    case ($urandom_range(0, 9))
      0: l = 11'd0;
      1: l = 11'($urandom_range(1025, 2047));
      2: l = 11'd1024;
      default: l = 11'($urandom_range(1, 1024));
    endcase
    return l;
  endfunction

  // Random traffic: receptions near the window with plausible acks, mixed with sends and ticks.
  task automatic queue_random(int count);
    logic [31:0] s, a;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: enqueue(mk(swt_pkg::OP_SEND, 32'd0, 32'd0, 16'($urandom), rnd_len()));
        3, 4: enqueue(mk(swt_pkg::OP_TICK, $urandom, $urandom, 16'($urandom),
                         11'($urandom)));
        9: begin
          if ($urandom_range(0, 2) == 0)
            enqueue(mk(swt_pkg::OP_NONE, $urandom, $urandom, 16'($urandom),
                       11'($urandom)));
          else
            enqueue(mk(swt_pkg::OP_RX, $urandom, $urandom, 16'($urandom),
                       11'($urandom)));
        end
        default: begin
          s = ($urandom_range(0, 4) == 0) ? 32'd0 : 32'(i / 2) + $urandom_range(0, 12);
          a = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'(i / 4) + $urandom_range(0, 6);
          enqueue(mk(swt_pkg::OP_RX, s, a, 16'($urandom), 11'($urandom)));
        end
      endcase
    end
  endtask

  task automatic write_reg(swt_pkg::cfg_idx_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == swt_pkg::CFG_WINDOW) win_reg = val[5:0];
    else tmo_reg = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || start || expected_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    win_reg = 6'd20; tmo_reg = 16'd5;
    rx_next = 32'd1; tx_next = 32'd1; tx_acked = 32'd0; tx_full = 1'b0;
    tmr_on = 1'b0; tmr_cnt = 16'd0;
    for (int i = 0; i < int'(swt_pkg::RxDepth); i++) rx_held[i] = 1'b0;
    for (int i = 0; i < int'(swt_pkg::TxDepth); i++) tx_store[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: out-of-order reception, duplicates, window edge, refusals.
    write_reg(swt_pkg::CFG_WINDOW, 16'd2);
    write_reg(swt_pkg::CFG_TIMEOUT, 16'd1);
    enqueue(mk(swt_pkg::OP_RX, 32'd0, 32'd0, 16'h1111, 11'd1));
    enqueue(mk(swt_pkg::OP_RX, 32'd3, 32'd0, 16'hFFFF, 11'h7FF));
    enqueue(mk(swt_pkg::OP_RX, 32'd3, 32'd0, 16'h0000, 11'd5));
    enqueue(mk(swt_pkg::OP_RX, 32'd33, 32'd0, 16'h2222, 11'd7));
    enqueue(mk(swt_pkg::OP_RX, 32'hFFFFFFFF, 32'd0, 16'h3333, 11'd9));
    enqueue(mk(swt_pkg::OP_RX, 32'd2, 32'd0, 16'h4444, 11'd1024));
    enqueue(mk(swt_pkg::OP_RX, 32'd1, 32'd0, 16'h5555, 11'd0));
    enqueue(mk(swt_pkg::OP_TICK, 32'd0, 32'd0, 16'd0, 11'd0));
    enqueue(mk(swt_pkg::OP_SEND, 32'd0, 32'd0, 16'hAAAA, 11'd0));
    enqueue(mk(swt_pkg::OP_SEND, 32'd0, 32'd0, 16'hAAAA, 11'd1025));
    enqueue(mk(swt_pkg::OP_SEND, 32'd0, 32'd0, 16'hFFFF, 11'd1024));
    enqueue(mk(swt_pkg::OP_SEND, 32'd0, 32'd0, 16'h0001, 11'd1));
    enqueue(mk(swt_pkg::OP_SEND, 32'd0, 32'd0, 16'h0002, 11'd2));
    enqueue(mk(swt_pkg::OP_TICK, 32'd0, 32'd0, 16'd0, 11'd0));
    enqueue(mk(swt_pkg::OP_RX, 32'd0, 32'hFFFFFFFF, 16'd0, 11'd0));
    enqueue(mk(swt_pkg::OP_RX, 32'd0, 32'd5, 16'd0, 11'd0));
    enqueue(mk(swt_pkg::OP_RX, 32'd0, 32'd1, 16'd0, 11'd0));
    enqueue(mk(swt_pkg::OP_RX, 32'd0, 32'd2, 16'd0, 11'd0));
    enqueue(mk(swt_pkg::OP_TICK, 32'd0, 32'd0, 16'd0, 11'd0));
    enqueue(mk(swt_pkg::OP_NONE, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 11'h7FF));
    drain();

    write_reg(swt_pkg::CFG_WINDOW, 16'd0);
    write_reg(swt_pkg::CFG_TIMEOUT, 16'd0);
    queue_random(60);
    drain();
    write_reg(swt_pkg::CFG_WINDOW, 16'd63);
    write_reg(swt_pkg::CFG_TIMEOUT, 16'd3);
    queue_random(80);
    drain();
    write_reg(swt_pkg::CFG_WINDOW, 16'd32);
    write_reg(swt_pkg::CFG_TIMEOUT, 16'hFFFF);
    queue_random(60);
    drain();
    write_reg(swt_pkg::CFG_WINDOW, 16'd7);
    write_reg(swt_pkg::CFG_TIMEOUT, 16'd2);
    queue_random(100);
    drain();

    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
`default_nettype wire

### files.f
sv/swt_pkg.sv
sv/sliding_window_transport.sv
sv/swt_checker.sv
tb/testbench.sv
